// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/tsr_pkg.sv -----
// Shared types and constants of the tile scanline renderer
`default_nettype none
package tsr_pkg;

    localparam int VIDEO_ADDR_BITS = 14;
    localparam logic [7:0] LAST_LINE = 8'd191;

    localparam logic [5:0] CELLS_GFX  = 6'd32;
    localparam logic [5:0] CELLS_TEXT = 6'd40;
    localparam logic [3:0] WIDTH_GFX  = 4'd8;
    localparam logic [3:0] WIDTH_TEXT = 4'd6;

    localparam logic [2:0] REG_MODE_A     = 3'd0;
    localparam logic [2:0] REG_MODE_B     = 3'd1;
    localparam logic [2:0] REG_NAME_BASE  = 3'd2;
    localparam logic [2:0] REG_COLOR_BASE = 3'd3;
    localparam logic [2:0] REG_PAT_BASE   = 3'd4;
    localparam logic [2:0] REG_COLORS     = 3'd5;

    localparam int MODE_A_GM2_BIT   = 1;
    localparam int MODE_B_MULTI_BIT = 3;
    localparam int MODE_B_TEXT_BIT  = 4;

    localparam logic [7:0] MULTI_PATTERN = 8'hF0;

    typedef logic [VIDEO_ADDR_BITS-1:0] t_vaddr;

    typedef struct packed {
        logic       we;
        logic       rd;
        t_vaddr     addr;
        logic [7:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic       multi;
        logic       text;
        logic [7:0] pattern;
        logic [7:0] color;
        logic [7:0] colors_reg;
    } t_pix_in;

endpackage
`default_nettype wire

// ----- hw/rtl/tile_scanline_renderer.sv -----
// Top level of the tile scanline renderer
//
// Input stream (s_axis): one beat per item. tuser = 0 writes tdata's byte into
// the 16K video memory in the cycle of the beat; tuser = 1 renders the line in
// tdata and blocks the input until its last cell has been loaded into the
// output register.
// Output stream (m_axis): one beat per character cell, 32 cells (40 in text
// mode). tlast marks the final cell of the line, tuser the final cell of the
// last visible line.
// Sequence: a render reads the first name, then for each cell the pattern, the colour
// and, but for the last cell, the next name (name, pattern and colour reads share the
// single memory port). The first cell is loaded into the output register in S_PIX,
// after the states S_NAME, S_PAT and S_COL.
// Back-pressure: a cell that finds the output register full waits, holding
// its colour byte, until the receiver takes the pending beat.
// Reset: synchronous, active low; clears the mode registers, the sequencer
// and the output valid. Video memory is not cleared and must be loaded first.
// Configuration via i_cfg_* must be written while no render is in progress; unenforced.
`default_nettype none
module tile_scanline_renderer
    import tsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // write_address[13:0], write_data[21:14], line[29:22], zero pad
    input  wire logic [31:0] s_axis_tdata,
    // kind
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cell_column[5:0], pixel_x[13:6], pixel_colors[45:14], pixel_count[49:46], zero pad
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // frame_end
    output logic             m_axis_tuser
);

    t_mem_req    mem_req;
    logic [7:0]  mem_rdata;
    t_pix_in     pix_in;
    logic [31:0] pixels;

    tsr_vram u_vram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    tsr_pix u_pix (
        .i_pin    (pix_in),
        .o_pixels (pixels)
    );

    tsr_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_mem_req     (mem_req),
        .i_mem_rdata   (mem_rdata),
        .o_pix_in      (pix_in),
        .i_pixels      (pixels)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_vram.sv -----
// Single-port video memory, 16K x 8, registered read
`default_nettype none
module tsr_vram
    import tsr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**VIDEO_ADDR_BITS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_pix.sv -----
// Colour selection and pixel packing for one character cell
`default_nettype none
module tsr_pix
    import tsr_pkg::*;
(
    input  wire t_pix_in i_pin,
    output logic [31:0]  o_pixels
);

    always_comb begin
        logic [3:0] fg;
        logic [3:0] bg;
        logic [7:0] pat;
        logic [3:0] c;
        if (i_pin.multi) begin
            fg  = i_pin.pattern[7:4];
            bg  = i_pin.pattern[3:0];
            pat = MULTI_PATTERN;
        end else begin
            fg  = i_pin.text ? i_pin.colors_reg[7:4] : i_pin.color[7:4];
            bg  = (i_pin.color[3:0] == 4'd0 || i_pin.text) ? i_pin.colors_reg[3:0]
                                                            : i_pin.color[3:0];
            pat = i_pin.pattern;
        end
        o_pixels = '0;
        for (int i = 0; i < 8; i++) begin
            c = pat[7-i] ? fg : bg;
            if (i_pin.text && i >= 6) begin
                c = 4'd0;
            end
            o_pixels[31-4*i -: 4] = c;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_seq.sv -----
// Cell sequencer: registers, video memory addressing and output stage
`default_nettype none
module tsr_seq
    import tsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,
    output t_mem_req         o_mem_req,
    input  wire logic [7:0]  i_mem_rdata,
    output t_pix_in          o_pix_in,
    input  wire logic [31:0] i_pixels
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NAME = 5'b00010,
        S_PAT  = 5'b00100,
        S_COL  = 5'b01000,
        S_PIX  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_mode_a, r_mode_b, r_color_base, r_colors;
    logic [3:0]  r_name_base;
    logic [2:0]  r_pat_base;
    logic [7:0]  r_line;
    logic [5:0]  r_cell;
    t_vaddr      r_name_ptr;
    logic [7:0]  r_name;
    logic [7:0]  r_pattern;
    logic        r_out_valid;
    logic [55:0] r_out_data;
    logic        r_out_last;
    logic        r_out_frame;

    logic        text, multi, gm2;
    logic        s_acc, emit, last;
    logic [4:0]  row;
    logic [10:0] row_off;
    t_vaddr      start_ptr, pat_addr, col_addr;
    logic [7:0]  px;

    assign text  = r_mode_b[MODE_B_TEXT_BIT];
    assign multi = r_mode_b[MODE_B_MULTI_BIT];
    assign gm2   = r_mode_a[MODE_A_GM2_BIT];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign emit  = (r_state == S_PIX) && (!r_out_valid || m_axis_tready);
    assign last  = r_cell == (text ? CELLS_TEXT - 6'd1 : CELLS_GFX - 6'd1);

    // start of the name row for the requested line
    assign row     = s_axis_tdata[29:25];
    assign row_off = text ? (11'({row, 5'b0}) + 11'({row, 3'b0})) : 11'({row, 5'b0});
    assign start_ptr = t_vaddr'({r_name_base, 10'b0}) + t_vaddr'(row_off);

    // pattern address from the name byte just read
    always_comb begin
        if (multi) begin
            pat_addr = {r_pat_base, i_mem_rdata, r_line[4:2]};
        end else if (!gm2) begin
            pat_addr = {r_pat_base, i_mem_rdata, r_line[2:0]};
        end else begin
            pat_addr = {r_pat_base[2], r_name_ptr[9:8] & r_pat_base[1:0],
                        i_mem_rdata, r_line[2:0]};
        end
    end

    always_comb begin
        if (multi) begin
            col_addr = '0;
        end else if (!gm2) begin
            col_addr = {r_color_base, 1'b0, r_name[7:3]};
        end else begin
            col_addr = {r_color_base[7], r_color_base[6:0] & {r_name_ptr[9:8], r_name[7:3]},
                        r_name[2:0], r_line[2:0]};
        end
    end

    always_comb begin
        o_mem_req = '0;
        unique case (r_state)
            S_IDLE: begin
                o_mem_req.we    = s_acc && !s_axis_tuser;
                o_mem_req.addr  = s_axis_tdata[13:0];
                o_mem_req.wdata = s_axis_tdata[21:14];
            end
            S_NAME: begin
                o_mem_req.rd   = 1'b1;
                o_mem_req.addr = r_name_ptr;
            end
            S_PAT: begin
                o_mem_req.rd   = 1'b1;
                o_mem_req.addr = pat_addr;
            end
            S_COL: begin
                o_mem_req.rd   = 1'b1;
                o_mem_req.addr = col_addr;
            end
            S_PIX: begin
                o_mem_req.rd   = emit && !last;
                o_mem_req.addr = r_name_ptr + t_vaddr'(1);
            end
            default: o_mem_req = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_acc && s_axis_tuser) n_state = S_NAME;
            S_NAME:  n_state = S_PAT;
            S_PAT:   n_state = S_COL;
            S_COL:   n_state = S_PIX;
            S_PIX:   if (emit) n_state = last ? S_IDLE : S_PAT;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pix_in.multi      = multi;
    assign o_pix_in.text       = text;
    assign o_pix_in.pattern    = r_pattern;
    assign o_pix_in.color      = i_mem_rdata;
    assign o_pix_in.colors_reg = r_colors;

    assign px = text ? (8'({r_cell, 2'b0}) + 8'({r_cell, 1'b0})) : 8'({r_cell, 3'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode_a     <= '0;
            r_mode_b     <= '0;
            r_name_base  <= '0;
            r_color_base <= '0;
            r_pat_base   <= '0;
            r_colors     <= '0;
            r_cell       <= '0;
            r_name_ptr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    REG_MODE_A:     r_mode_a     <= i_cfg_data;
                    REG_MODE_B:     r_mode_b     <= i_cfg_data;
                    REG_NAME_BASE:  r_name_base  <= i_cfg_data[3:0];
                    REG_COLOR_BASE: r_color_base <= i_cfg_data;
                    REG_PAT_BASE:   r_pat_base   <= i_cfg_data[2:0];
                    REG_COLORS:     r_colors     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_acc && s_axis_tuser) begin
                r_cell     <= '0;
                r_name_ptr <= start_ptr;
            end
            if (emit) begin
                r_cell     <= r_cell + 6'd1;
                r_name_ptr <= r_name_ptr + t_vaddr'(1);
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_line <= s_axis_tdata[29:22];
        end
        if (r_state == S_PAT) begin
            r_name <= i_mem_rdata;
        end
        if (r_state == S_COL) begin
            r_pattern <= i_mem_rdata;
        end
        if (emit) begin
            r_out_data  <= {6'b0, text ? WIDTH_TEXT : WIDTH_GFX, i_pixels, px, r_cell};
            r_out_last  <= last;
            r_out_frame <= last && (r_line == LAST_LINE);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_frame;

endmodule
`default_nettype wire

// ----- hw/rtl/tsr_checker.sv -----
// Port-level checks of the tile scanline renderer, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tsr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)
    `ASSERT_NEXT(a_render_busy, i_clk, i_rst_n, s_beat && s_axis_tuser, !s_axis_tready)
    `ASSERT_NEXT(a_write_silent, i_clk, i_rst_n,
                 s_beat && !s_axis_tuser && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid)

endmodule

bind tile_scanline_renderer tsr_checker u_tsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
`default_nettype wire
